[sv/pidq_pkg.sv]
package pidq_pkg;

  localparam int unsigned CMD_W         = 3;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned DEPTH_DEFAULT = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BEYOND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[sv/pidq_if.sv]
interface pidq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pidq_pkg::CMD_W-1:0]    command;
  logic signed [pidq_pkg::VAL_W-1:0]    value;
  logic        [pidq_pkg::POS_W-1:0]    position;
  logic        [pidq_pkg::POS_W-1:0]    run_length;

  modport source (output valid, command, value, position, run_length, input ready);
  modport sink   (input valid, command, value, position, run_length, output ready);
endinterface

interface pidq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pidq_pkg::STAT_W-1:0]   status;
  logic                                 found;
  logic        [pidq_pkg::POS_W-1:0]    found_position;
  logic signed [pidq_pkg::VAL_W-1:0]    front_value;
  logic        [pidq_pkg::POS_W-1:0]    occupancy;

  modport source (output valid, status, found, found_position, front_value, occupancy,
                  input ready);
  modport sink   (input valid, status, found, found_position, front_value, occupancy,
                  output ready);
endinterface

[sv/pidq_cell.sv]
module pidq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 4
) (
  input  logic                                 clk_i,
  input  pidq_pkg::cell_ctl_t                  ctl_i,
  input  logic        [IDX_W-1:0]              slot_i,
  input  logic signed [pidq_pkg::VAL_W-1:0]    left_i,
  input  logic signed [pidq_pkg::VAL_W-1:0]    right_i,
  output logic signed [pidq_pkg::VAL_W-1:0]    data_o,
  output logic                                 match_o
);
  import pidq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [VAL_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (MY_IDX > slot_i) begin
          data_d = left_i;
        end else if (MY_IDX == slot_i) begin
          data_d = ctl_i.value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= slot_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == ctl_i.value);

endmodule

[sv/positional_insert_delete_queue.sv]
// sequencing: push, pop, insert, unused codes and error reports go straight to the result
//   state; delete removes the run one entry per cycle (the run clipped at the back), search
//   walks the latched match flags from the front to the first hit, or goes straight on a miss
// throughput: one item in flight; the next item is taken the cycle after the result moves
//   to the output register; a stalled output holds the input
// reset: asynchronous active low, queue empty; entry data is not reset
module positional_insert_delete_queue #(
  parameter int unsigned DEPTH = pidq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pidq_in_if.sink            in_i,
  pidq_out_if.source         out_o
);
  import pidq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CMP_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [DEPTH-1:0]     vec_q, vec_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  status_e              stat_q, stat_d;
  logic                 found_q, found_d;
  logic [POS_W-1:0]     fpos_q, fpos_d;

  logic                 out_valid_q;
  status_e              out_stat_q;
  logic                 out_found_q;
  logic [POS_W-1:0]     out_fpos_q;
  logic signed [VAL_W-1:0] out_front_q;
  logic [POS_W-1:0]     out_occ_q;

  logic                 accept;
  logic                 res_load;
  logic [CMP_W-1:0]     slot_cmp;
  logic [CMP_W-1:0]     count_cmp;
  logic [CMP_W-1:0]     avail;
  logic [CMP_W-1:0]     run_cmp;
  logic [CMP_W-1:0]     del_n;
  logic                 is_full;
  logic                 is_empty;

  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     cell_slot;
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]     cell_match;
  logic [DEPTH-1:0]     held_match;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign res_load = (state_q == S_RES) && (!out_valid_q || out_o.ready);

  // 1-based position to slot, 0 and 1 both mean the front
  assign slot_cmp  = (in_i.position <= POS_W'(1)) ? '0 : CMP_W'(in_i.position - POS_W'(1));
  assign count_cmp = CMP_W'(count_q);
  assign run_cmp   = CMP_W'(in_i.run_length);
  assign avail     = count_cmp - slot_cmp;
  assign del_n     = (run_cmp < avail) ? run_cmp : avail;
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);

  // the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_data[i];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    pidq_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .slot_i  (cell_slot),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );

    // only held entries take part in a search
    assign held_match[i] = cell_match[i] && (CNT_W'(i) < count_q);
  end

  // command decode and sequencing
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    slot_d    = slot_q;
    vec_d     = vec_q;
    scan_d    = scan_q;
    stat_d    = stat_q;
    found_d   = found_q;
    fpos_d    = fpos_q;
    ctl.op    = CELL_HOLD;
    ctl.value = in_i.value;
    cell_slot = slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d  = STAT_OK;
          found_d = 1'b0;
          fpos_d  = '0;
          state_d = S_RES;
          case (in_i.command)
            CMD_PUSH: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else begin
                ctl.op    = CELL_INSERT;
                cell_slot = IDX_W'(count_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                stat_d = STAT_EMPTY;
              end else begin
                ctl.op    = CELL_DELETE;
                cell_slot = '0;
                count_d   = count_q - CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (is_full) begin
                stat_d = STAT_FULL;
              end else if (slot_cmp > count_cmp) begin
                stat_d = STAT_BEYOND;
              end else begin
                ctl.op    = CELL_INSERT;
                cell_slot = IDX_W'(slot_cmp);
                count_d   = count_q + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (is_empty) begin
                stat_d = STAT_EMPTY;
              end else if (slot_cmp >= count_cmp) begin
                stat_d = STAT_BEYOND;
              end else begin
                // run is clipped at the back, then removed one entry a cycle
                rem_d   = del_n;
                slot_d  = IDX_W'(slot_cmp);
                state_d = S_DEL;
              end
            end
            CMD_SEARCH: begin
              if (is_empty) begin
                stat_d = STAT_EMPTY;
              end else begin
                vec_d   = held_match;
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            default: stat_d = STAT_OK;
          endcase
        end
      end
      S_DEL: begin
        if (rem_q == '0) begin
          state_d = S_RES;
        end else begin
          ctl.op  = CELL_DELETE;
          rem_d   = rem_q - CMP_W'(1);
          count_d = count_q - CNT_W'(1);
        end
      end
      S_SCAN: begin
        // walk the latched match flags from the front, first hit wins
        if (vec_q == '0) begin
          state_d = S_RES;
        end else if (vec_q[0]) begin
          found_d = 1'b1;
          fpos_d  = POS_W'(scan_q + CNT_W'(1));
          state_d = S_RES;
        end else begin
          vec_d  = vec_q >> 1;
          scan_d = scan_q + CNT_W'(1);
        end
      end
      S_RES: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    slot_q  <= slot_d;
    vec_q   <= vec_d;
    scan_q  <= scan_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    fpos_q  <= fpos_d;
    if (res_load) begin
      out_stat_q  <= stat_q;
      out_found_q <= found_q;
      out_fpos_q  <= fpos_q;
      out_front_q <= is_empty ? '0 : cell_data[0];
      out_occ_q   <= POS_W'(count_q);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_stat_q;
  assign out_o.found          = out_found_q;
  assign out_o.found_position = out_fpos_q;
  assign out_o.front_value    = out_front_q;
  assign out_o.occupancy      = out_occ_q;

endmodule

[dv/positional_insert_delete_queue_test.sv]
module positional_insert_delete_queue_test;
  import pidq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned PHASES       = 4;
  // worst case: deep delete or search plus long stalls on both sides
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // longest latency (delete of a full run or a search hit at the back) with margin
  localparam int unsigned TAIL_CYCLES  = 40;

  // command codes the block does not decode; they must leave the queue alone
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct {
    logic        [CMD_W-1:0] command;
    logic signed [VAL_W-1:0] value;
    logic        [POS_W-1:0] position;
    logic        [POS_W-1:0] run_length;
  } queue_cmd_t;

  // what the block reports after each command
  typedef struct {
    status_e                 status;
    logic                    found;
    logic        [POS_W-1:0] found_position;
    logic signed [VAL_W-1:0] front_value;
    logic        [POS_W-1:0] occupancy;
  } queue_report_t;

  // one directed row: a command, how often it repeats (value counts up),
  // and a report typed in by hand when it is obvious
  typedef struct {
    logic        [CMD_W-1:0] command;
    logic signed [VAL_W-1:0] value;
    logic        [POS_W-1:0] position;
    logic        [POS_W-1:0] run_length;
    int unsigned             reps;
    bit                      typed;
    status_e                 status;
    logic                    found;
    logic        [POS_W-1:0] found_position;
    logic signed [VAL_W-1:0] front_value;
    logic        [POS_W-1:0] occupancy;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pidq_in_if  in_if ();
  pidq_out_if out_if ();

  positional_insert_delete_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the queue, front at index 0
  logic signed [VAL_W-1:0] shadow_entries [$];
  // reports owed by the block, oldest first
  queue_report_t           reports_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned failures;
  int unsigned reports_checked;
  int unsigned cycle_count;
  int unsigned cmd_seen [8];
  int unsigned status_seen [4];
  int unsigned search_hits;
  bit          growing;

  // idle mix per random phase: none, sender idle, receiver stalls, both
  int unsigned send_idle_by_phase  [PHASES] = '{0, 82, 0, 15};
  int unsigned recv_stall_by_phase [PHASES] = '{0, 0, 82, 15};

  stim_row_t directed_rows [22] = '{
    // empty queue: every command that needs an entry reports empty
    '{CMD_POP,       32'h0,         5'd0,  5'd0,  1,  1'b1, STAT_EMPTY,  1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_DELETE,    32'h0,         5'd1,  5'd1,  1,  1'b1, STAT_EMPTY,  1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_SEARCH,    32'h0,         5'd0,  5'd0,  1,  1'b1, STAT_EMPTY,  1'b0, 5'd0, 32'h0,  5'd0},
    // insert past the back of an empty queue
    '{CMD_INSERT,    32'h5,         5'd2,  5'd0,  1,  1'b1, STAT_BEYOND, 1'b0, 5'd0, 32'h0,  5'd0},
    // insert at position zero means the front
    '{CMD_INSERT,    32'h7fffffff,  5'd0,  5'd0,  1,  1'b1, STAT_OK,     1'b0, 5'd0,
      32'h7fffffff, 5'd1},
    '{CMD_PUSH,      32'h80000000,  5'd0,  5'd0,  1,  1'b1, STAT_OK,     1'b0, 5'd0,
      32'h7fffffff, 5'd2},
    '{CMD_INSERT,    32'hffffffff,  5'd1,  5'd0,  1,  1'b1, STAT_OK,     1'b0, 5'd0,
      32'hffffffff, 5'd3},
    // occupancy plus one appends at the back
    '{CMD_INSERT,    32'h0,         5'd4,  5'd0,  1,  1'b1, STAT_OK,     1'b0, 5'd0,
      32'hffffffff, 5'd4},
    '{CMD_INSERT,    32'h9,         5'd31, 5'd0,  1,  1'b1, STAT_BEYOND, 1'b0, 5'd0,
      32'hffffffff, 5'd4},
    '{CMD_SEARCH,    32'h80000000,  5'd0,  5'd0,  1,  1'b1, STAT_OK,     1'b1, 5'd3,
      32'hffffffff, 5'd4},
    '{CMD_UNUSED_HI, 32'h0,         5'd0,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    // fill up to the top
    '{CMD_PUSH,      32'd100,       5'd0,  5'd0,  12, 1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_PUSH,      32'h1,         5'd0,  5'd0,  1,  1'b1, STAT_FULL,   1'b0, 5'd0,
      32'hffffffff, 5'd16},
    // insert into a full queue reports full; full is checked before the position
    '{CMD_INSERT,    32'h2,         5'd1,  5'd0,  1,  1'b1, STAT_FULL,   1'b0, 5'd0,
      32'hffffffff, 5'd16},
    '{CMD_SEARCH,    32'h5555aaaa,  5'd0,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_DELETE,    32'h0,         5'd17, 5'd1,  1,  1'b1, STAT_BEYOND, 1'b0, 5'd0,
      32'hffffffff, 5'd16},
    // zero run length removes nothing
    '{CMD_DELETE,    32'h0,         5'd2,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    // run longer than what is left stops at the back
    '{CMD_DELETE,    32'h0,         5'd15, 5'd31, 1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_DELETE,    32'h0,         5'd0,  5'd16, 1,  1'b1, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_UNUSED_LO, 32'h0,         5'd0,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_PUSH,      32'h2a,        5'd0,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0},
    '{CMD_POP,       32'h0,         5'd0,  5'd0,  1,  1'b0, STAT_OK,     1'b0, 5'd0, 32'h0,  5'd0}
  };

  // apply one command to the shadow queue and return the report it should produce
  function automatic queue_report_t apply_to_shadow(queue_cmd_t cmd);
    queue_report_t rep;
    int unsigned   count;
    int unsigned   slot;
    int unsigned   n;
    rep.status         = STAT_OK;
    rep.found          = 1'b0;
    rep.found_position = '0;
    count = shadow_entries.size();
    // positions are 1-based, zero and one both select the front
    slot  = (cmd.position <= 1) ? 0 : cmd.position - 1;
    case (cmd.command)
      CMD_PUSH: begin
        if (count >= QUEUE_DEPTH) rep.status = STAT_FULL;
        else shadow_entries.push_back(cmd.value);
      end
      CMD_POP: begin
        if (count == 0) rep.status = STAT_EMPTY;
        else void'(shadow_entries.pop_front());
      end
      CMD_INSERT: begin
        if (count >= QUEUE_DEPTH) rep.status = STAT_FULL;
        else if (slot > count) rep.status = STAT_BEYOND;
        else shadow_entries.insert(slot, cmd.value);
      end
      CMD_DELETE: begin
        if (count == 0) rep.status = STAT_EMPTY;
        else if (slot >= count) rep.status = STAT_BEYOND;
        else begin
          n = (cmd.run_length < count - slot) ? cmd.run_length : count - slot;
          repeat (n) shadow_entries.delete(slot);
        end
      end
      CMD_SEARCH: begin
        if (count == 0) rep.status = STAT_EMPTY;
        else begin
          // first match wins
          for (int unsigned i = 0; i < count; i++) begin
            if (!rep.found && shadow_entries[i] == cmd.value) begin
              rep.found          = 1'b1;
              rep.found_position = POS_W'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    rep.occupancy   = POS_W'(shadow_entries.size());
    rep.front_value = (shadow_entries.size() > 0) ? shadow_entries[0] : '0;
    cmd_seen[cmd.command]++;
    status_seen[rep.status]++;
    if (rep.found) search_hits++;
    return rep;
  endfunction

  // random command; swings between filling and draining so both ends get hit
  function automatic queue_cmd_t pick_random_cmd();
    queue_cmd_t  cmd;
    int unsigned occ;
    int unsigned roll;
    occ = shadow_entries.size();
    if (occ >= QUEUE_DEPTH) growing = 1'b0;
    else if (occ == 0) growing = 1'b1;
    roll = $urandom_range(99);
    if (roll < 3) cmd.command = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    else if (roll < 15) cmd.command = CMD_SEARCH;
    else if ($urandom_range(99) < (growing ? 65 : 25))
      cmd.command = $urandom_range(1) ? CMD_PUSH : CMD_INSERT;
    else
      cmd.command = $urandom_range(1) ? CMD_POP : CMD_DELETE;
    // small value pool so searches hit and duplicates show up
    case ($urandom_range(9))
      0, 1:    cmd.value = $urandom();
      2:       cmd.value = 32'h7fffffff;
      3:       cmd.value = 32'h80000000;
      default: cmd.value = VAL_W'($urandom_range(5));
    endcase
    if (cmd.command == CMD_SEARCH && occ > 0 && $urandom_range(1))
      cmd.value = shadow_entries[$urandom_range(occ - 1)];
    // positions mostly around the live range, sometimes anywhere in the field
    if ($urandom_range(9) == 0) cmd.position = POS_W'($urandom_range(31));
    else cmd.position = POS_W'($urandom_range(occ + 2));
    if ($urandom_range(9) == 0) cmd.run_length = POS_W'($urandom_range(31));
    else cmd.run_length = POS_W'($urandom_range(4));
    return cmd;
  endfunction

  // present one item, hold it until taken, then record the report it owes
  task automatic issue_command(input queue_cmd_t cmd, input bit typed,
                               input queue_report_t typed_report);
    queue_report_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd.command;
    in_if.value      <= cmd.value;
    in_if.position   <= cmd.position;
    in_if.run_length <= cmd.run_length;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = apply_to_shadow(cmd);
    reports_due.push_back(typed ? typed_report : predicted);
  endtask

  // stop sending and wait for every owed report
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
  endtask

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // receiver: ready decided at each falling edge
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // check each taken report against the oldest one owed
  always @(posedge clk_i) begin : report_check
    queue_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $error("report with nothing owed: status %0d occupancy %0d",
               out_if.status, out_if.occupancy);
        failures++;
      end else begin
        want = reports_due.pop_front();
        reports_checked++;
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          failures++;
        end
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_if.found);
          failures++;
        end
        if (out_if.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, out_if.found_position);
          failures++;
        end
        if (out_if.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, out_if.front_value);
          failures++;
        end
        if (out_if.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_if.occupancy);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    queue_cmd_t    cmd;
    queue_report_t rep;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_PUSH;
    in_if.value      = '0;
    in_if.position   = '0;
    in_if.run_length = '0;
    out_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    failures         = 0;
    reports_checked  = 0;
    cycle_count      = 0;
    search_hits      = 0;
    growing          = 1'b1;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, repeated rows count the value up
    foreach (directed_rows[r]) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
        cmd.command        = directed_rows[r].command;
        cmd.value          = directed_rows[r].value + k;
        cmd.position       = directed_rows[r].position;
        cmd.run_length     = directed_rows[r].run_length;
        rep.status         = directed_rows[r].status;
        rep.found          = directed_rows[r].found;
        rep.found_position = directed_rows[r].found_position;
        rep.front_value    = directed_rows[r].front_value;
        rep.occupancy      = directed_rows[r].occupancy;
        issue_command(cmd, directed_rows[r].typed, rep);
      end
    end
    wait_drained();

    // random phases, each with its own idle mix; the sender drains between phases
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      for (int unsigned k = 0; k < RANDOM_ITEMS / PHASES; k++)
        issue_command(pick_random_cmd(), 1'b0, rep);
      wait_drained();
    end

    // let any stray report show up
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran push %0d, pop %0d, insert %0d, delete %0d, search %0d, unused %0d items",
             cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_INSERT],
             cmd_seen[CMD_DELETE], cmd_seen[CMD_SEARCH],
             cmd_seen[CMD_UNUSED_LO] + cmd_seen[CMD_UNUSED_MID] + cmd_seen[CMD_UNUSED_HI]);
    $display("%0d reports checked: ok %0d, empty %0d, full %0d, beyond %0d, %0d search hits",
             reports_checked, status_seen[STAT_OK], status_seen[STAT_EMPTY],
             status_seen[STAT_FULL], status_seen[STAT_BEYOND], search_hits);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
sv/pidq_pkg.sv
sv/pidq_if.sv
sv/pidq_cell.sv
sv/positional_insert_delete_queue.sv
dv/positional_insert_delete_queue_test.sv
